// ===== hdl/cbps_pkg.sv =====
`timescale 1ns / 1ps

package cbps_pkg;

	localparam int PATTERN_MAX_DEF = 64;

	localparam int REQ_TYPE_W  = 2;
	localparam int INDEX_W     = 6;
	localparam int BYTE_W      = 8;
	localparam int STATUS_W    = 2;
	localparam int OFFSET_W    = 48;
	localparam int LEN_CFG_W   = 7;
	localparam int CHUNK_W     = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 48;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [REQ_TYPE_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_BYTE = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_END  = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHUNK_SIZE     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_OFFSET   = 2'd2;

	localparam logic [LEN_CFG_W-1:0] PATTERN_LENGTH_RST = 7'd1;
	localparam logic [CHUNK_W-1:0]   CHUNK_SIZE_RST     = 32'd512;
	localparam logic [OFFSET_W-1:0]  START_OFFSET_RST   = 48'd0;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_BYTE = 2'd1,
		OP_END  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_MATCH    = 2'd0,
		ST_NONE     = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef struct packed {
		op_t               op;
		logic [INDEX_W-1:0] index;
		logic [BYTE_W-1:0]  data;
	} entry_t;

endpackage

// ===== hdl/cbps_req_if.sv =====
`timescale 1ns / 1ps

interface cbps_req_if;
	logic                             valid;
	logic                             ready;
	logic [cbps_pkg::REQ_TYPE_W-1:0]  req_type;
	logic [cbps_pkg::INDEX_W-1:0]     pattern_index;
	logic [cbps_pkg::BYTE_W-1:0]      data_byte;

	modport source(output valid, output req_type, output pattern_index, output data_byte,
		input ready);
	modport sink(input valid, input req_type, input pattern_index, input data_byte,
		output ready);
endinterface

// ===== hdl/cbps_res_if.sv =====
`timescale 1ns / 1ps

interface cbps_res_if;
	logic                           valid;
	logic                           ready;
	logic [cbps_pkg::STATUS_W-1:0]  status;
	logic [cbps_pkg::OFFSET_W-1:0]  match_offset;

	modport source(output valid, output status, output match_offset, input ready);
	modport sink(input valid, input status, input match_offset, output ready);
endinterface

// ===== hdl/cbps_front.sv =====
`timescale 1ns / 1ps

module cbps_front #(
	parameter int PATTERN_MAX = cbps_pkg::PATTERN_MAX_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	cbps_req_if.sink         req,
	output cbps_pkg::entry_t push_entry,
	output logic             push_valid,
	input  logic             push_ready
);

	logic             vld_s1;
	cbps_pkg::entry_t entry_s1;
	cbps_pkg::entry_t entry_d;
	logic             keep;
	logic             accept;

	assign req.ready = !vld_s1 || push_ready;
	assign accept    = req.valid && req.ready;

	// unknown request types and out-of-range loads are dropped here
	always_comb begin
		entry_d.index = req.pattern_index;
		entry_d.data  = req.data_byte;
		entry_d.op    = cbps_pkg::OP_BYTE;
		keep          = 1'b0;
		case (req.req_type)
			cbps_pkg::REQ_LOAD: begin
				entry_d.op = cbps_pkg::OP_LOAD;
				keep       = 32'(req.pattern_index) < 32'(PATTERN_MAX);
			end
			cbps_pkg::REQ_BYTE: begin
				entry_d.op = cbps_pkg::OP_BYTE;
				keep       = 1'b1;
			end
			cbps_pkg::REQ_END: begin
				entry_d.op = cbps_pkg::OP_END;
				keep       = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1 <= entry_d;
		end
	end

	assign push_valid = vld_s1;
	assign push_entry = entry_s1;

endmodule

// ===== hdl/cbps_queue.sv =====
`timescale 1ns / 1ps

module cbps_queue #(
	parameter int DEPTH = cbps_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cbps_pkg::entry_t push_entry,
	input  logic             push_valid,
	output logic             push_ready,
	output cbps_pkg::entry_t head,
	output logic             head_valid,
	input  logic             pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

	cbps_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== hdl/cbps_back.sv =====
`timescale 1ns / 1ps

module cbps_back #(
	parameter int PATTERN_MAX = cbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  cbps_pkg::entry_t                     head,
	input  logic                                 head_valid,
	output logic                                 pop,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]     eff_len,
	input  logic [cbps_pkg::CHUNK_W-1:0]         chunk_size,
	input  logic [cbps_pkg::OFFSET_W-1:0]        start_offset,
	cbps_res_if.source                           rsp
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);
	localparam int VEC_W = PATTERN_MAX * cbps_pkg::BYTE_W;
	localparam logic [LEN_W-1:0] PM_L = LEN_W'(PATTERN_MAX);

	logic [cbps_pkg::BYTE_W-1:0]   pat_q [PATTERN_MAX];
	logic [cbps_pkg::BYTE_W-1:0]   win_q [PATTERN_MAX];
	logic [cbps_pkg::BYTE_W-1:0]   win_n [PATTERN_MAX];
	logic [cbps_pkg::CHUNK_W-1:0]  pos_q;
	logic [cbps_pkg::OFFSET_W-1:0] cnt_q;
	logic                          fin_q;

	logic                          rsp_vld_q;
	cbps_pkg::status_t             rsp_status_q;
	logic [cbps_pkg::OFFSET_W-1:0] rsp_off_q;

	logic [VEC_W-1:0]              rvec;
	logic [VEC_W-1:0]              shifted;
	logic [LEN_W-1:0]              shamt;
	logic [PATTERN_MAX-1:0]        eq;
	logic [PATTERN_MAX-1:0]        mask;
	logic                          hit;
	logic                          too_long;
	logic [cbps_pkg::CHUNK_W-1:0]  pos_base;
	logic [cbps_pkg::CHUNK_W-1:0]  pos_n;
	logic                          reached;
	logic [cbps_pkg::OFFSET_W-1:0] offset;
	logic                          out_free;
	logic                          has_res;
	cbps_pkg::status_t             res_status;
	logic [cbps_pkg::OFFSET_W-1:0] res_off;
	logic                          match;

	// window after taking this beat, newest byte first
	always_comb begin
		win_n[0] = head.data;
		for (int k = 1; k < PATTERN_MAX; k++) begin
			win_n[k] = win_q[k-1];
		end
	end

	// reversed window shifted so byte i lines up with pattern byte i
	always_comb begin
		for (int j = 0; j < PATTERN_MAX; j++) begin
			rvec[j*cbps_pkg::BYTE_W +: cbps_pkg::BYTE_W] = win_n[PATTERN_MAX-1-j];
		end
	end

	assign shamt   = PM_L - eff_len;
	assign shifted = rvec >> {shamt, 3'b000};

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			eq[i]   = shifted[i*cbps_pkg::BYTE_W +: cbps_pkg::BYTE_W] == pat_q[i];
			mask[i] = 32'(i) < 32'(eff_len);
		end
	end

	assign hit      = &(eq | ~mask);
	assign too_long = 32'(eff_len) > chunk_size;
	assign pos_base = (pos_q >= chunk_size) ? '0 : pos_q;
	assign pos_n    = pos_base + 1'b1;
	assign reached  = pos_n >= 32'(eff_len);
	assign match    = reached && hit;
	assign offset   = start_offset + cnt_q - cbps_pkg::OFFSET_W'(eff_len - 1'b1);

	assign out_free = !rsp_vld_q || rsp.ready;
	assign pop      = head_valid && (head.op == cbps_pkg::OP_LOAD || out_free);

	always_comb begin
		has_res    = 1'b0;
		res_status = cbps_pkg::ST_NONE;
		res_off    = '0;
		case (head.op)
			cbps_pkg::OP_BYTE: begin
				if (!fin_q) begin
					if (too_long) begin
						has_res    = 1'b1;
						res_status = cbps_pkg::ST_TOO_LONG;
					end else if (match) begin
						has_res    = 1'b1;
						res_status = cbps_pkg::ST_MATCH;
						res_off    = offset;
					end
				end
			end
			cbps_pkg::OP_END: begin
				if (!fin_q) begin
					has_res    = 1'b1;
					res_status = too_long ? cbps_pkg::ST_TOO_LONG : cbps_pkg::ST_NONE;
				end
			end
			default: begin
				has_res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (pop) begin
			case (head.op)
				cbps_pkg::OP_BYTE: begin
					if (!fin_q) begin
						if (too_long) begin
							fin_q <= 1'b1;
						end else begin
							pos_q <= pos_n;
							cnt_q <= cnt_q + 1'b1;
							fin_q <= match;
						end
					end
				end
				cbps_pkg::OP_END: begin
					pos_q <= '0;
					cnt_q <= '0;
					fin_q <= 1'b0;
				end
				default: begin
					fin_q <= fin_q;
				end
			endcase
		end
	end

	// window bytes older than the chunk start are never compared
	always_ff @(posedge clk) begin
		if (pop && head.op == cbps_pkg::OP_BYTE && !fin_q && !too_long) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= win_n[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < PATTERN_MAX; k++) begin
			if (pop && head.op == cbps_pkg::OP_LOAD && 32'(head.index) == k) begin
				pat_q[k] <= head.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (out_free) begin
			rsp_vld_q <= pop && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && pop && has_res) begin
			rsp_status_q <= res_status;
			rsp_off_q    <= res_off;
		end
	end

	assign rsp.valid        = rsp_vld_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.match_offset = rsp_off_q;

endmodule

// ===== hdl/chunked_byte_pattern_search.sv =====
`timescale 1ns / 1ps

// Searches a byte stream for the first occurrence of a loaded pattern, with
// matches confined to chunks of chunk_size bytes. Pattern bytes, haystack
// bytes and end beats all enter on req; at most one beat leaves on rsp per
// search: a match with its absolute offset, a no-match at the end beat, or a
// pattern-longer-than-chunk error. The block takes one req beat every clock
// cycle as long as rsp is drained; a result passes the front register, the
// queue and the rsp register before it shows. The rate is set by the back
// unit, which shifts the window and compares all pattern bytes against it
// combinationally, and a four-beat queue in front of it absorbs short stalls
// on rsp. Configuration must be written by the user through cfg_we, cfg_index
// and cfg_wdata while no beat is in flight; the block does not enforce it.
module chunked_byte_pattern_search #(
	parameter int PATTERN_MAX = cbps_pkg::PATTERN_MAX_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	cbps_req_if.sink                            req,
	cbps_res_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [cbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cbps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int LEN_W = $clog2(PATTERN_MAX + 1);

	logic [cbps_pkg::LEN_CFG_W-1:0] len_q;
	logic [cbps_pkg::CHUNK_W-1:0]   chunk_q;
	logic [cbps_pkg::OFFSET_W-1:0]  start_q;
	logic [LEN_W-1:0]               eff_len;

	cbps_pkg::entry_t push_entry;
	logic             push_valid;
	logic             push_ready;
	cbps_pkg::entry_t head;
	logic             head_valid;
	logic             pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= cbps_pkg::PATTERN_LENGTH_RST;
			chunk_q <= cbps_pkg::CHUNK_SIZE_RST;
			start_q <= cbps_pkg::START_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cbps_pkg::CFG_PATTERN_LENGTH: len_q   <= cfg_wdata[cbps_pkg::LEN_CFG_W-1:0];
				cbps_pkg::CFG_CHUNK_SIZE:     chunk_q <= cfg_wdata[cbps_pkg::CHUNK_W-1:0];
				cbps_pkg::CFG_START_OFFSET:   start_q <= cfg_wdata[cbps_pkg::OFFSET_W-1:0];
				default: begin
					len_q <= len_q;
				end
			endcase
		end
	end

	// zero acts as one, anything above the window depth as the full depth
	always_comb begin
		if (len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(len_q) > 32'(PATTERN_MAX)) begin
			eff_len = LEN_W'(PATTERN_MAX);
		end else begin
			eff_len = LEN_W'(len_q);
		end
	end

	cbps_front #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	cbps_queue #(
		.DEPTH(cbps_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_entry (push_entry),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	cbps_back #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.eff_len      (eff_len),
		.chunk_size   (chunk_q),
		.start_offset (start_q),
		.rsp          (rsp)
	);

endmodule
